@@ rtl/core/bbpe_pkg.sv @@
// bbpe_pkg: shared types and constants of the byte-level bpe merge core
// used by the controller, the datapath and the top level
`timescale 1ns / 1ps

package bbpe_pkg;

  localparam int TOK_W = 18;

  typedef enum logic [1:0] {
    CMD_LOAD_MAP  = 2'd0,
    CMD_LOAD_RULE = 2'd1,
    CMD_DATA      = 2'd2,
    CMD_NOP       = 2'd3
  } bbpe_cmd_code_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_UNMAPPED = 2'd1,
    ERR_OVERFLOW = 2'd2,
    ERR_RSVD     = 2'd3
  } bbpe_err_t;

  typedef enum logic [4:0] {
    ST_CLR,
    ST_IDLE,
    ST_RULE,
    ST_BYTE,
    ST_DECIDE,
    ST_SC_INIT,
    ST_SC_A,
    ST_SC_B,
    ST_LK,
    ST_SC_UPD,
    ST_RW_INIT,
    ST_RW_A,
    ST_RW_B,
    ST_RW_END,
    ST_EM_RD,
    ST_EM_LD,
    ST_EO_LD,
    ST_EM_WAIT
  } bbpe_state_t;

  typedef struct packed {
    logic accept;
    logic rule_wr;
    logic byte_apply;
    logic clear;
    logic clr_run;
    logic sc_init;
    logic sc_a;
    logic lk_start;
    logic lk_run;
    logic sc_upd;
    logic rw_init;
    logic rw_a;
    logic rw_b;
    logic rw_end;
    logic em_start;
    logic em_rd;
    logic em_ld;
    logic eo_ld;
    logic em_fire;
  } bbpe_cmd_t;

  typedef struct packed {
    logic in_rule;
    logic in_data;
    logic clr_done;
    logic last;
    logic err_nz;
    logic cnt_zero;
    logic cnt_lt2;
    logic lk_done;
    logic scan_more;
    logic found_any;
    logic has_b;
    logic rw_match;
    logic rw_more;
    logic out_last;
    logic out_fire;
  } bbpe_sts_t;

endpackage

@@ rtl/core/bbpe_ctrl.sv @@
// bbpe_ctrl: state machine sequencing loads, merge rounds and token output
// depends on bbpe_pkg
`timescale 1ns / 1ps

module bbpe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  bbpe_pkg::bbpe_sts_t sts,
  output bbpe_pkg::bbpe_cmd_t cmd,
  output logic               in_tready
);
  import bbpe_pkg::*;

  bbpe_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR:     if (sts.clr_done) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_tvalid) begin
          if (sts.in_rule)      state_nxt = ST_RULE;
          else if (sts.in_data) state_nxt = ST_BYTE;
        end
      end
      ST_RULE:    state_nxt = ST_IDLE;
      ST_BYTE:    state_nxt = sts.last ? ST_DECIDE : ST_IDLE;
      ST_DECIDE: begin
        if (sts.err_nz)        state_nxt = ST_EO_LD;
        else if (sts.cnt_zero) state_nxt = ST_IDLE;
        else if (sts.cnt_lt2)  state_nxt = ST_EM_RD;
        else                   state_nxt = ST_SC_INIT;
      end
      ST_SC_INIT: state_nxt = ST_SC_A;
      ST_SC_A:    state_nxt = ST_SC_B;
      ST_SC_B:    state_nxt = ST_LK;
      ST_LK:      if (sts.lk_done) state_nxt = ST_SC_UPD;
      ST_SC_UPD: begin
        if (sts.scan_more)      state_nxt = ST_SC_B;
        else if (sts.found_any) state_nxt = ST_RW_INIT;
        else                    state_nxt = ST_EM_RD;
      end
      ST_RW_INIT: state_nxt = ST_RW_A;
      ST_RW_A:    state_nxt = sts.has_b ? ST_RW_B : ST_RW_END;
      ST_RW_B: begin
        if (sts.rw_match && !sts.rw_more) state_nxt = ST_RW_END;
        else                              state_nxt = ST_RW_A;
      end
      ST_RW_END:  state_nxt = ST_DECIDE;
      ST_EM_RD:   state_nxt = ST_EM_LD;
      ST_EM_LD:   state_nxt = ST_EM_WAIT;
      ST_EO_LD:   state_nxt = ST_EM_WAIT;
      ST_EM_WAIT: begin
        if (sts.out_fire) state_nxt = sts.out_last ? ST_IDLE : ST_EM_RD;
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_CLR:     cmd.clr_run = 1'b1;
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      ST_RULE:    cmd.rule_wr = 1'b1;
      ST_BYTE:    cmd.byte_apply = 1'b1;
      ST_DECIDE: begin
        cmd.clear    = !sts.err_nz && sts.cnt_zero;
        cmd.em_start = !sts.err_nz && !sts.cnt_zero && sts.cnt_lt2;
      end
      ST_SC_INIT: cmd.sc_init = 1'b1;
      ST_SC_A:    cmd.sc_a = 1'b1;
      ST_SC_B:    cmd.lk_start = 1'b1;
      ST_LK:      cmd.lk_run = 1'b1;
      ST_SC_UPD: begin
        cmd.sc_upd   = 1'b1;
        cmd.em_start = !sts.scan_more && !sts.found_any;
      end
      ST_RW_INIT: cmd.rw_init = 1'b1;
      ST_RW_A:    cmd.rw_a = 1'b1;
      ST_RW_B:    cmd.rw_b = 1'b1;
      ST_RW_END:  cmd.rw_end = 1'b1;
      ST_EM_RD:   cmd.em_rd = 1'b1;
      ST_EM_LD:   cmd.em_ld = 1'b1;
      ST_EO_LD:   cmd.eo_ld = 1'b1;
      ST_EM_WAIT: cmd.em_fire = sts.out_fire;
      default:    cmd = '0;
    endcase
  end

endmodule

@@ rtl/core/bbpe_dp.sv @@
// bbpe_dp: byte map, merge table, slot list, symbol buffer and output register
// depends on bbpe_pkg; driven by bbpe_ctrl commands
`timescale 1ns / 1ps

module bbpe_dp #(
  parameter int MAX_SYMBOLS  = 64,
  parameter int RULE_ENTRIES = 262144
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bbpe_pkg::bbpe_cmd_t cmd,
  output bbpe_pkg::bbpe_sts_t sts,
  input  logic [119:0]        in_tdata,
  input  logic [1:0]          in_tuser,
  input  logic                in_tlast,
  input  logic                out_tready,
  output logic                out_tvalid,
  output logic [23:0]         out_tdata,
  output logic                out_tlast,
  output logic [1:0]          out_tuser
);
  import bbpe_pkg::*;

  localparam int SW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int CW = SW + 1;
  localparam int RW = $clog2(RULE_ENTRIES);
  localparam int UW = RW + 1;
  localparam int KW = 2 * TOK_W + 1;
  localparam int VW = 2 * TOK_W;

  // input fields
  logic [7:0]       in_bval;
  logic [TOK_W-1:0] in_btok, in_slot, in_pl, in_pr, in_rank, in_mtok;
  assign in_bval = in_tdata[7:0];
  assign in_btok = in_tdata[25:8];
  assign in_slot = in_tdata[43:26];
  assign in_pl   = in_tdata[61:44];
  assign in_pr   = in_tdata[79:62];
  assign in_rank = in_tdata[97:80];
  assign in_mtok = in_tdata[115:98];

  logic             slot_ok;
  assign slot_ok = ({1'b0, in_slot} < (TOK_W+1)'(RULE_ENTRIES));
  assign sts.in_rule = (in_tuser == CMD_LOAD_RULE) && slot_ok;
  assign sts.in_data = (in_tuser == CMD_DATA);

  // captured item
  logic             last_r;
  logic [RW-1:0]    slot_r;
  logic [TOK_W-1:0] pl_r, pr_r, rank_r, mtok_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      last_r <= in_tlast;
      slot_r <= in_slot[RW-1:0];
      pl_r   <= in_pl;
      pr_r   <= in_pr;
      rank_r <= in_rank;
      mtok_r <= in_mtok;
    end
  end

  // byte map
  logic [255:0]     map_vld_r;
  logic [TOK_W-1:0] map_mem [256];
  logic [TOK_W-1:0] map_q;
  logic             map_vld_q;
  logic             map_wr;
  assign map_wr = cmd.accept && (in_tuser == CMD_LOAD_MAP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_vld_r <= '0;
    end else if (map_wr) begin
      map_vld_r[in_bval] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (map_wr) begin
      map_mem[in_bval] <= in_btok;
    end
    map_q     <= map_mem[in_bval];
    map_vld_q <= map_vld_r[in_bval];
  end

  // merge table, indexed by slot
  logic [KW-1:0]    key_mem [RULE_ENTRIES];
  logic [VW-1:0]    val_mem [RULE_ENTRIES];
  logic [KW-1:0]    key_q;
  logic [VW-1:0]    val_q;
  logic [RW-1:0]    key_rd_addr, used_q, clr_idx_r;
  logic [UW-1:0]    used_cnt_r, j_r;
  logic [RW-1:0]    used_mem [RULE_ENTRIES];

  assign key_rd_addr = cmd.accept ? in_slot[RW-1:0] : used_q;
  assign sts.clr_done = (clr_idx_r == RW'(RULE_ENTRIES - 1));

  always_ff @(posedge clk) begin
    if (cmd.clr_run) begin
      key_mem[clr_idx_r] <= '0;
    end else if (cmd.rule_wr) begin
      key_mem[slot_r] <= {1'b1, pl_r, pr_r};
    end
    key_q <= key_mem[key_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.rule_wr) begin
      val_mem[slot_r] <= {rank_r, mtok_r};
    end
    val_q <= val_mem[key_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.rule_wr && !key_q[KW-1]) begin
      used_mem[used_cnt_r[RW-1:0]] <= slot_r;
    end
    used_q <= used_mem[j_r[RW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r  <= '0;
      used_cnt_r <= '0;
    end else begin
      if (cmd.clr_run) clr_idx_r <= clr_idx_r + RW'(1);
      if (cmd.rule_wr && !key_q[KW-1]) used_cnt_r <= used_cnt_r + UW'(1);
    end
  end

  // symbol buffer and counters
  logic [TOK_W-1:0] sym_mem [MAX_SYMBOLS];
  logic [TOK_W-1:0] sym_q, sym_wdata;
  logic [SW-1:0]    sym_raddr, sym_waddr;
  logic             sym_we;
  logic [CW-1:0]    cnt_r, i_r, w_r, e_r;
  logic [1:0]       err_r;
  logic [CW:0]      i_p1, i_p2, cnt_x;
  logic [TOK_W-1:0] a_r, b_r;

  assign i_p1  = {1'b0, i_r} + (CW+1)'(1);
  assign i_p2  = {1'b0, i_r} + (CW+1)'(2);
  assign cnt_x = {1'b0, cnt_r};

  // lookup and round state
  logic             p1_r, p2_r, lhit_r, found_r, pair_hit;
  logic [RW-1:0]    slot2_r, lslot_r;
  logic [TOK_W-1:0] lrank_r, lres_r, best_rank_r, best_res_r, best_l_r, best_r_r;
  logic             use_new;

  assign pair_hit = p2_r && (key_q == {1'b1, a_r, b_r}) && (!lhit_r || slot2_r < lslot_r);
  assign use_new  = lhit_r && (!found_r || lrank_r < best_rank_r);

  assign sts.last      = last_r;
  assign sts.err_nz    = (err_r != ERR_NONE);
  assign sts.cnt_zero  = (cnt_r == '0);
  assign sts.cnt_lt2   = (cnt_r < CW'(2));
  assign sts.lk_done   = (j_r >= used_cnt_r) && !p1_r && !p2_r;
  assign sts.scan_more = (i_p2 < cnt_x);
  assign sts.found_any = found_r || lhit_r;
  assign sts.has_b     = (i_p1 < cnt_x);
  assign sts.rw_match  = (a_r == best_l_r) && (sym_q == best_r_r);
  assign sts.rw_more   = (i_p2 < cnt_x);

  always_comb begin
    sym_raddr = '0;
    if (cmd.sc_a || cmd.rw_a)  sym_raddr = i_p1[SW-1:0];
    else if (cmd.sc_upd)       sym_raddr = i_p2[SW-1:0];
    else if (cmd.rw_b)         sym_raddr = sts.rw_match ? i_p2[SW-1:0] : i_p1[SW-1:0];
    else if (cmd.em_rd)        sym_raddr = e_r[SW-1:0];
  end

  always_comb begin
    sym_we    = 1'b0;
    sym_waddr = w_r[SW-1:0];
    sym_wdata = a_r;
    if (cmd.byte_apply) begin
      sym_we    = map_vld_q && (cnt_r != CW'(MAX_SYMBOLS));
      sym_waddr = cnt_r[SW-1:0];
      sym_wdata = map_q;
    end else if (cmd.rw_a) begin
      sym_we    = !sts.has_b;
      sym_wdata = sym_q;
    end else if (cmd.rw_b) begin
      sym_we    = 1'b1;
      sym_wdata = sts.rw_match ? best_res_r : a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (sym_we) begin
      sym_mem[sym_waddr] <= sym_wdata;
    end
    sym_q <= sym_mem[sym_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      err_r <= ERR_NONE;
    end else begin
      if (cmd.byte_apply) begin
        if (!map_vld_q) begin
          if (err_r == ERR_NONE) err_r <= ERR_UNMAPPED;
        end else if (cnt_r == CW'(MAX_SYMBOLS)) begin
          if (err_r == ERR_NONE) err_r <= ERR_OVERFLOW;
        end else begin
          cnt_r <= cnt_r + CW'(1);
        end
      end
      if (cmd.rw_end) cnt_r <= w_r;
      if (cmd.clear || (cmd.em_fire && out_tlast)) begin
        cnt_r <= '0;
        err_r <= ERR_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sc_init) begin
      i_r     <= '0;
      found_r <= 1'b0;
    end
    if (cmd.sc_a) a_r <= sym_q;
    if (cmd.lk_start) begin
      b_r    <= sym_q;
      j_r    <= '0;
      p1_r   <= 1'b0;
      p2_r   <= 1'b0;
      lhit_r <= 1'b0;
    end
    if (cmd.lk_run) begin
      if (j_r < used_cnt_r) begin
        j_r  <= j_r + UW'(1);
        p1_r <= 1'b1;
      end else begin
        p1_r <= 1'b0;
      end
      p2_r    <= p1_r;
      slot2_r <= used_q;
      if (pair_hit) begin
        lhit_r  <= 1'b1;
        lslot_r <= slot2_r;
        lrank_r <= val_q[VW-1:TOK_W];
        lres_r  <= val_q[TOK_W-1:0];
      end
    end
    if (cmd.sc_upd) begin
      if (use_new) begin
        found_r     <= 1'b1;
        best_rank_r <= lrank_r;
        best_res_r  <= lres_r;
        best_l_r    <= a_r;
        best_r_r    <= b_r;
      end
      a_r <= b_r;
      i_r <= i_p1[CW-1:0];
    end
    if (cmd.rw_init) begin
      i_r <= '0;
      w_r <= '0;
    end
    if (cmd.rw_a) begin
      a_r <= sym_q;
      if (!sts.has_b) begin
        w_r <= w_r + CW'(1);
        i_r <= i_p1[CW-1:0];
      end
    end
    if (cmd.rw_b) begin
      w_r <= w_r + CW'(1);
      i_r <= sts.rw_match ? i_p2[CW-1:0] : i_p1[CW-1:0];
    end
    if (cmd.em_start) e_r <= '0;
    if (cmd.em_fire)  e_r <= e_r + CW'(1);
  end

  // output register
  logic             out_vld_r, out_last_r;
  logic [TOK_W-1:0] out_tok_r;
  logic [1:0]       out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.em_ld || cmd.eo_ld) begin
      out_vld_r <= 1'b1;
    end else if (cmd.em_fire) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.em_ld) begin
      out_tok_r  <= sym_q;
      out_last_r <= ({1'b0, e_r} + (CW+1)'(1)) == cnt_x;
      out_err_r  <= ERR_NONE;
    end else if (cmd.eo_ld) begin
      out_tok_r  <= '0;
      out_last_r <= 1'b1;
      out_err_r  <= err_r;
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = {6'd0, out_tok_r};
  assign out_tlast    = out_last_r;
  assign out_tuser    = out_err_r;
  assign sts.out_last = out_last_r;
  assign sts.out_fire = out_vld_r && out_tready;

endmodule

@@ rtl/core/byte_level_bpe_merge_core.sv @@
// byte_level_bpe_merge_core: top level of the byte-level bpe merge engine
// depends on bbpe_pkg, bbpe_ctrl and bbpe_dp
//
// input beats carry a command in in_tuser: byte map load, merge rule load or
// pretoken data byte; in_tlast marks the final byte of a pretoken.
// loads and non-final bytes give no output beat. the final byte runs the merge
// rounds and then streams the symbols out, the final one with out_tlast set;
// a pending error gives a single beat with token 0, out_tlast and the code in
// out_tuser.
// one beat in at a time: in_tready is high only while the block is idle.
// each merge round walks the pairs, and each pair lookup scans the list of
// written rule slots; a rewrite pass then writes the merged symbols back.
// each output token is read, loaded into the output register and held until
// out_tready takes it. after reset the rule table is swept clear with
// in_tready low. a stalled receiver simply holds the output beat and the
// block waits.
`timescale 1ns / 1ps

module byte_level_bpe_merge_core #(
  parameter int MAX_SYMBOLS  = 64,
  parameter int RULE_ENTRIES = 262144
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // byte_value, byte_token, rule_slot, pair_left, pair_right, merge_rank,
  // merged_token, zero pad
  input  logic [119:0] in_tdata,
  input  logic [1:0]   in_tuser,  // command
  input  logic         in_tlast,  // last_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [23:0]  out_tdata, // emitted token, zero pad
  output logic [1:0]   out_tuser, // error_code
  output logic         out_tlast  // last_token
);
  import bbpe_pkg::*;

  bbpe_cmd_t cmd;
  bbpe_sts_t sts;

  bbpe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .sts       (sts),
    .cmd       (cmd),
    .in_tready (in_tready)
  );

  bbpe_dp #(
    .MAX_SYMBOLS  (MAX_SYMBOLS),
    .RULE_ENTRIES (RULE_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

@@ rtl/core/bbpe_chk.sv @@
// bbpe_chk: port-level checks of the byte-level bpe merge core
// bound to byte_level_bpe_merge_core; depends on bbpe_pkg
`timescale 1ns / 1ps

module bbpe_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [23:0]  out_tdata,
  input logic [1:0]   out_tuser,
  input logic         out_tlast
);
  import bbpe_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ERR_NONE |-> out_tlast && out_tdata == 24'd0)
    else $error("error beat not a lone last beat");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while output pending");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("activity right after reset");

endmodule

bind byte_level_bpe_merge_core bbpe_chk u_bbpe_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
